>>> hdl/scs_pkg.sv
// scs_pkg: shared types, constants and byte-space functions of the
// southbridge configuration space; used by scs_dma and the top level
`default_nettype none
package scs_pkg;

  localparam int unsigned FnCount = 4;
  localparam int unsigned SpaceDepth = 256;
  localparam int unsigned DmaChannels = 8;
  localparam int unsigned DmaPageWidth = 12;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [7:0] ABSENT_BYTE   = 8'hff;
  localparam logic [7:0] DMA_FIRST_OFF = 8'h60;
  localparam logic [7:0] DMA_LAST_OFF  = 8'h6f;
  localparam logic [7:0] DMA_RO_EVEN   = 8'h68;
  localparam logic [7:0] DMA_RO_ODD    = 8'h69;
  localparam logic [7:0] ALIAS_FIRST   = 8'h70;
  localparam logic [7:0] ALIAS_LAST    = 8'h72;
  localparam logic [7:0] ALIAS_SHIFT   = 8'h44;
  localparam logic [7:0] CPU_RST_OFF   = 8'h47;
  localparam logic [7:0] CPU_RST_BITS  = 8'h81;

  typedef struct packed {
    logic       en;
    logic [7:0] off;
    logic [7:0] data;
  } wr_req_t;

  function automatic logic [7:0] cs_default(input logic [1:0] fn, input logic [7:0] off);
    logic [7:0] r;
    r = 8'h00;
    unique case (fn)
      2'd0: begin
        unique case (off)
          8'h00: r = 8'h06; 8'h01: r = 8'h11; 8'h02: r = 8'h86; 8'h03: r = 8'h05;
          8'h04: r = 8'h0f; 8'h07: r = 8'h02; 8'h0a: r = 8'h01; 8'h0b: r = 8'h06;
          8'h0e: r = 8'h80; 8'h48: r = 8'h01; 8'h4a: r = 8'h04; 8'h4f: r = 8'h03;
          8'h50: r = 8'h24; 8'h59: r = 8'h04;
          default: r = 8'h00;
        endcase
      end
      2'd1: begin
        unique case (off)
          8'h00: r = 8'h06; 8'h01: r = 8'h11; 8'h02: r = 8'h71; 8'h03: r = 8'h05;
          8'h04: r = 8'h80; 8'h06: r = 8'h80; 8'h07: r = 8'h02; 8'h09: r = 8'h85;
          8'h0a: r = 8'h01; 8'h0b: r = 8'h01; 8'h10: r = 8'hf1; 8'h11: r = 8'h01;
          8'h14: r = 8'hf5; 8'h15: r = 8'h03; 8'h18: r = 8'h71; 8'h19: r = 8'h01;
          8'h1c: r = 8'h75; 8'h1d: r = 8'h03; 8'h20: r = 8'h01; 8'h21: r = 8'hcc;
          8'h3c: r = 8'h0e; 8'h40: r = 8'h08; 8'h41: r = 8'h02; 8'h42: r = 8'h09;
          8'h43: r = 8'h3a; 8'h44: r = 8'h68; 8'h46: r = 8'hc0; 8'h48: r = 8'ha8;
          8'h49: r = 8'ha8; 8'h4a: r = 8'ha8; 8'h4b: r = 8'ha8; 8'h4c: r = 8'hff;
          8'h4e: r = 8'hff; 8'h4f: r = 8'hff; 8'h50: r = 8'h03; 8'h51: r = 8'h03;
          8'h52: r = 8'h03; 8'h53: r = 8'h03; 8'h61: r = 8'h02; 8'h69: r = 8'h02;
          default: r = 8'h00;
        endcase
      end
      2'd2: begin
        unique case (off)
          8'h00: r = 8'h06; 8'h01: r = 8'h11; 8'h02: r = 8'h38; 8'h03: r = 8'h30;
          8'h07: r = 8'h02; 8'h0a: r = 8'h03; 8'h0b: r = 8'h0c; 8'h0d: r = 8'h16;
          8'h20: r = 8'h01; 8'h21: r = 8'h03; 8'h3d: r = 8'h04; 8'h60: r = 8'h10;
          8'hc1: r = 8'h20;
          default: r = 8'h00;
        endcase
      end
      default: begin
        unique case (off)
          8'h00: r = 8'h06; 8'h01: r = 8'h11; 8'h02: r = 8'h40; 8'h03: r = 8'h30;
          8'h06: r = 8'h80; 8'h07: r = 8'h02; 8'h08: r = 8'h10; 8'h48: r = 8'h01;
          default: r = 8'h00;
        endcase
      end
    endcase
    return r;
  endfunction

  // offsets whose writes land in the byte space (dma range excluded)
  function automatic logic cs_writable(input logic [1:0] fn, input logic [7:0] off);
    logic w;
    w = 1'b0;
    unique case (fn)
      2'd0: w = (off == 8'h04) || (off == 8'h06) || (off == 8'h47) || (off == 8'h48) ||
                (off >= 8'h55 && off <= 8'h58) || (off == 8'h5b) ||
                (off >= ALIAS_FIRST && off <= ALIAS_LAST);
      2'd1: w = (off == 8'h04) || (off == 8'h06) || (off == 8'h07) || (off == 8'h09) ||
                (off == 8'h0d) || (off == 8'h10) || (off == 8'h11) || (off == 8'h13) ||
                (off == 8'h14) || (off == 8'h15) || (off == 8'h17) || (off == 8'h18) ||
                (off == 8'h19) || (off == 8'h1b) || (off == 8'h1c) || (off == 8'h1d) ||
                (off == 8'h1f) || (off == 8'h20) || (off == 8'h21) || (off == 8'h3c) ||
                (off >= 8'h40 && off <= 8'h51);
      2'd2: w = (off == 8'h04) || (off == 8'h07) || (off == 8'h20) || (off == 8'h0d) ||
                (off == 8'h21) || (off == 8'h3c) || (off == 8'h3d) || (off == 8'h40) ||
                (off == 8'h41) || (off == 8'h44) || (off == 8'h45) || (off == 8'hc0) ||
                (off == 8'hc1);
      default: w = (off == 8'h0d) || (off >= 8'h40 && off <= 8'h42) ||
                   (off >= 8'h44 && off <= 8'h47) || (off == 8'h49) ||
                   (off >= 8'h50 && off <= 8'h53);
    endcase
    return w;
  endfunction

  function automatic logic [7:0] cs_target(input logic [1:0] fn, input logic [7:0] off);
    if (fn == 2'd0 && off >= ALIAS_FIRST && off <= ALIAS_LAST) return off - ALIAS_SHIFT;
    return off;
  endfunction

  // bytes that hold flops: writable targets
  function automatic logic cs_stored(input logic [1:0] fn, input logic [7:0] off);
    if (fn == 2'd0 && off >= 8'h2c && off <= 8'h2e) return 1'b1;
    if (fn == 2'd0 && off >= ALIAS_FIRST && off <= ALIAS_LAST) return 1'b0;
    return cs_writable(fn, off);
  endfunction

  function automatic logic [7:0] cs_wr_value(input logic [1:0] fn, input logic [7:0] off,
                                              input logic [7:0] v, input logic [7:0] old);
    logic [7:0] r;
    r = v;
    unique case (fn)
      2'd0: begin
        priority case (off)
          8'h04: r = (v & 8'h08) | 8'h07;
          8'h06: r = old & ~(v & 8'hb0);
          8'h47: r = v & 8'hfe;
          default: r = v;
        endcase
      end
      2'd1: begin
        priority case (off)
          8'h04: r = v & 8'h85;
          8'h06: r = old & ~(v & 8'hb0);
          8'h09: r = (v & 8'h05) | 8'h8a;
          8'h10, 8'h18: r = (v & 8'hf8) | 8'h01;
          8'h14, 8'h1c: r = (v & 8'hfc) | 8'h01;
          8'h20: r = (v & 8'hf0) | 8'h01;
          default: r = v;
        endcase
      end
      2'd2: begin
        priority case (off)
          8'h04: r = v & 8'h97;
          8'h07: r = v & 8'h7f;
          8'h20: r = (v & 8'he0) | 8'h01;
          default: r = v;
        endcase
      end
      default: r = v;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/scs_if.sv
// scs_in_if and scs_out_if: valid/ready channels of the configuration
// space; depend on nothing
`default_nettype none
interface scs_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [2:0] function_number;
  logic [7:0] offset;
  logic [7:0] write_byte;
  modport source(output valid, opcode, function_number, offset, write_byte, input ready);
  modport sink(input valid, opcode, function_number, offset, write_byte, output ready);
endinterface

interface scs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       cpu_reset_request;
  modport source(output valid, read_byte, cpu_reset_request, input ready);
  modport sink(input valid, read_byte, cpu_reset_request, output ready);
endinterface
`default_nettype wire

>>> hdl/southbridge_pci_config_space.sv
// southbridge_pci_config_space: top level of the four-function config space
// depends on scs_pkg, scs_if and scs_dma
//
// usage: one byte access per word on in_word (opcode, function_number,
// offset, write_byte); one result word per access on out_word
// (read_byte, cpu_reset_request). reads of functions 4 to 7 give 0xff
// and writes there are dropped; writes return read_byte 0
// timing: an access passes the input register, then the result register;
// throughput one access per cycle while out_word.ready stays high
// only bytes that writes land in hold flops, all other bytes are constant decode
// reset: synchronous, loads the default bytes, clears dma state and
// empties both pipeline registers
// stall: while out_word.ready is low the result is held and the input
// register fills, after which in_word.ready drops
`default_nettype none
module southbridge_pci_config_space (
  input  wire logic clk,
  input  wire logic rst_n,
  scs_in_if.sink    in_word,
  scs_out_if.source out_word
);
  logic       s1_valid_r;
  logic       s1_op_r;
  logic [2:0] s1_fn_r;
  logic [7:0] s1_off_r;
  logic [7:0] s1_data_r;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_rst_r;

  logic advance, s1_fire, present, wr_go;
  logic [7:0] tgt_off, old_byte, new_byte, rd_byte_nxt, dma_byte;
  logic [7:0] space_w [scs_pkg::FnCount][scs_pkg::SpaceDepth];
  scs_pkg::wr_req_t dma_wr;

  assign advance       = !out_valid_r || out_word.ready;
  assign in_word.ready = !s1_valid_r || advance;
  assign s1_fire       = s1_valid_r && advance;
  assign present       = (s1_fn_r[2] == 1'b0);
  assign wr_go         = s1_fire && s1_op_r == scs_pkg::OP_WRITE && present
                         && scs_pkg::cs_writable(s1_fn_r[1:0], s1_off_r);
  assign tgt_off       = scs_pkg::cs_target(s1_fn_r[1:0], s1_off_r);
  assign old_byte      = space_w[s1_fn_r[1:0]][tgt_off];
  assign new_byte      = scs_pkg::cs_wr_value(s1_fn_r[1:0], s1_off_r, s1_data_r, old_byte);

  genvar f, o;
  generate
    for (f = 0; f < scs_pkg::FnCount; f++) begin : g_fn
      for (o = 0; o < scs_pkg::SpaceDepth; o++) begin : g_off
        if (scs_pkg::cs_stored(2'(f), 8'(o))) begin : g_reg
          logic [7:0] byte_r;
          always_ff @(posedge clk) begin
            if (!rst_n) begin
              byte_r <= scs_pkg::cs_default(2'(f), 8'(o));
            end else if (wr_go && s1_fn_r[1:0] == 2'(f) && tgt_off == 8'(o)) begin
              byte_r <= new_byte;
            end
          end
          assign space_w[f][o] = byte_r;
        end else begin : g_const
          assign space_w[f][o] = scs_pkg::cs_default(2'(f), 8'(o));
        end
      end
    end
  endgenerate

  assign dma_wr.en   = s1_fire && s1_op_r == scs_pkg::OP_WRITE && s1_fn_r == 3'd0;
  assign dma_wr.off  = s1_off_r;
  assign dma_wr.data = s1_data_r;

  scs_dma u_dma (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (dma_wr),
    .rd_off  (s1_off_r),
    .rd_byte (dma_byte)
  );

  always_comb begin
    if (!present) begin
      rd_byte_nxt = scs_pkg::ABSENT_BYTE;
    end else if (s1_fn_r == 3'd0 && s1_off_r >= scs_pkg::DMA_FIRST_OFF
                 && s1_off_r <= scs_pkg::DMA_LAST_OFF) begin
      rd_byte_nxt = dma_byte;
    end else begin
      rd_byte_nxt = space_w[s1_fn_r[1:0]][s1_off_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_word.valid && in_word.ready) s1_valid_r <= 1'b1;
      else if (advance)                   s1_valid_r <= 1'b0;
      if (advance) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_word.valid && in_word.ready) begin
      s1_op_r   <= in_word.opcode;
      s1_fn_r   <= in_word.function_number;
      s1_off_r  <= in_word.offset;
      s1_data_r <= in_word.write_byte;
    end
    if (s1_fire) begin
      if (s1_op_r == scs_pkg::OP_WRITE) begin
        out_byte_r <= 8'h00;
        out_rst_r  <= s1_fn_r == 3'd0 && s1_off_r == scs_pkg::CPU_RST_OFF
                      && (s1_data_r & scs_pkg::CPU_RST_BITS) == scs_pkg::CPU_RST_BITS;
      end else begin
        out_byte_r <= rd_byte_nxt;
        out_rst_r  <= 1'b0;
      end
    end
  end

  assign out_word.valid             = out_valid_r;
  assign out_word.read_byte         = out_byte_r;
  assign out_word.cpu_reset_request = out_rst_r;
endmodule
`default_nettype wire

>>> hdl/scs_dma.sv
// scs_dma: page bits and enables of the eight dma channels of function 0
// depends on scs_pkg
`default_nettype none
module scs_dma (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire scs_pkg::wr_req_t wr,
  input  wire logic [7:0]      rd_off,
  output logic [7:0]           rd_byte
);
  logic [scs_pkg::DmaPageWidth-1:0] page_r [scs_pkg::DmaChannels];
  logic [scs_pkg::DmaChannels-1:0]  en_r;
  logic [2:0] wr_ch;
  logic [2:0] rd_ch;
  logic       wr_hit;

  assign wr_ch  = wr.off[3:1];
  assign rd_ch  = rd_off[3:1];
  assign wr_hit = wr.en && wr.off >= scs_pkg::DMA_FIRST_OFF && wr.off <= scs_pkg::DMA_LAST_OFF
                  && wr.off != scs_pkg::DMA_RO_EVEN && wr.off != scs_pkg::DMA_RO_ODD;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= '0;
      for (int i = 0; i < scs_pkg::DmaChannels; i++) page_r[i] <= '0;
    end else if (wr_hit) begin
      if (wr.off[0]) begin
        page_r[wr_ch][11:4] <= wr.data;
      end else begin
        page_r[wr_ch][3:0] <= wr.data[7:4];
        en_r[wr_ch]        <= wr.data[3];
      end
    end
  end

  always_comb begin
    if (rd_off[0]) rd_byte = page_r[rd_ch][11:4];
    else           rd_byte = {page_r[rd_ch][3:0], en_r[rd_ch], 3'b000};
  end
endmodule
`default_nettype wire

>>> hdl/scs_checker.sv
// scs_checker: port-level assertions on the configuration space top level
// depends on southbridge_pci_config_space, bound below
`default_nettype none
module scs_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] read_byte,
  input wire logic       cpu_reset_request
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(read_byte) && $stable(cpu_reset_request))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_rst_is_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && cpu_reset_request |-> read_byte == 8'h00)
    else $error("cpu reset flag on a read");

  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !(in_valid && in_ready) && $past(!(in_valid && in_ready)) && $past(rst_n)
    |=> !out_valid)
    else $error("result without an accepted access");
endmodule

bind southbridge_pci_config_space scs_checker u_scs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_word.valid),
  .in_ready          (in_word.ready),
  .out_valid         (out_word.valid),
  .out_ready         (out_word.ready),
  .read_byte         (out_word.read_byte),
  .cpu_reset_request (out_word.cpu_reset_request)
);
`default_nettype wire

>>> tb/sv/scs_tb_if.sv
// testbench copies of nothing: the channel interfaces come from hdl/scs_if.sv
// this file holds the scoreboard class of the config space testbench
// depends on scs_pkg
`timescale 1ns / 1ps
class scs_access_board;
  logic [7:0]  bridge_mem [256];
  logic [7:0]  ide_mem [256];
  logic [7:0]  usb_mem [256];
  logic [7:0]  power_mem [256];
  logic [11:0] dma_page [8];
  logic [7:0]  dma_en;
  logic [8:0]  pending_q[$];
  int          errors;

  function void clear_state();
    for (int i = 0; i < 256; i++) begin
      bridge_mem[i] = 8'h00; ide_mem[i] = 8'h00; usb_mem[i] = 8'h00; power_mem[i] = 8'h00;
    end
    for (int i = 0; i < 8; i++) dma_page[i] = 12'h000;
    dma_en = 8'h00;
    load_defaults();
    pending_q.delete();
  endfunction

  function void load_defaults();
    bridge_mem[8'h00] = 8'h06; bridge_mem[8'h01] = 8'h11; bridge_mem[8'h02] = 8'h86;
    bridge_mem[8'h03] = 8'h05; bridge_mem[8'h04] = 8'h0f; bridge_mem[8'h07] = 8'h02;
    bridge_mem[8'h0a] = 8'h01; bridge_mem[8'h0b] = 8'h06; bridge_mem[8'h0e] = 8'h80;
    bridge_mem[8'h48] = 8'h01; bridge_mem[8'h4a] = 8'h04; bridge_mem[8'h4f] = 8'h03;
    bridge_mem[8'h50] = 8'h24; bridge_mem[8'h59] = 8'h04;
    ide_mem[8'h00] = 8'h06; ide_mem[8'h01] = 8'h11; ide_mem[8'h02] = 8'h71;
    ide_mem[8'h03] = 8'h05; ide_mem[8'h04] = 8'h80; ide_mem[8'h06] = 8'h80;
    ide_mem[8'h07] = 8'h02; ide_mem[8'h09] = 8'h85; ide_mem[8'h0a] = 8'h01;
    ide_mem[8'h0b] = 8'h01; ide_mem[8'h10] = 8'hf1; ide_mem[8'h11] = 8'h01;
    ide_mem[8'h14] = 8'hf5; ide_mem[8'h15] = 8'h03; ide_mem[8'h18] = 8'h71;
    ide_mem[8'h19] = 8'h01; ide_mem[8'h1c] = 8'h75; ide_mem[8'h1d] = 8'h03;
    ide_mem[8'h20] = 8'h01; ide_mem[8'h21] = 8'hcc; ide_mem[8'h3c] = 8'h0e;
    ide_mem[8'h40] = 8'h08; ide_mem[8'h41] = 8'h02; ide_mem[8'h42] = 8'h09;
    ide_mem[8'h43] = 8'h3a; ide_mem[8'h44] = 8'h68; ide_mem[8'h46] = 8'hc0;
    ide_mem[8'h48] = 8'ha8; ide_mem[8'h49] = 8'ha8; ide_mem[8'h4a] = 8'ha8;
    ide_mem[8'h4b] = 8'ha8; ide_mem[8'h4c] = 8'hff; ide_mem[8'h4e] = 8'hff;
    ide_mem[8'h4f] = 8'hff; ide_mem[8'h50] = 8'h03; ide_mem[8'h51] = 8'h03;
    ide_mem[8'h52] = 8'h03; ide_mem[8'h53] = 8'h03; ide_mem[8'h61] = 8'h02;
    ide_mem[8'h69] = 8'h02;
    usb_mem[8'h00] = 8'h06; usb_mem[8'h01] = 8'h11; usb_mem[8'h02] = 8'h38;
    usb_mem[8'h03] = 8'h30; usb_mem[8'h07] = 8'h02; usb_mem[8'h0a] = 8'h03;
    usb_mem[8'h0b] = 8'h0c; usb_mem[8'h0d] = 8'h16; usb_mem[8'h20] = 8'h01;
    usb_mem[8'h21] = 8'h03; usb_mem[8'h3d] = 8'h04; usb_mem[8'h60] = 8'h10;
    usb_mem[8'hc1] = 8'h20;
    power_mem[8'h00] = 8'h06; power_mem[8'h01] = 8'h11; power_mem[8'h02] = 8'h40;
    power_mem[8'h03] = 8'h30; power_mem[8'h06] = 8'h80; power_mem[8'h07] = 8'h02;
    power_mem[8'h08] = 8'h10; power_mem[8'h48] = 8'h01;
  endfunction

  function logic [7:0] peek(logic [2:0] fn, logic [7:0] off);
    int ch;
    ch = off[3:1];
    if (fn > 3'd3) return scs_pkg::ABSENT_BYTE;
    if (fn == 3'd0 && off >= scs_pkg::DMA_FIRST_OFF && off <= scs_pkg::DMA_LAST_OFF) begin
      if (off[0]) return dma_page[ch][11:4];
      return {dma_page[ch][3:0], dma_en[ch], 3'b000};
    end
    case (fn)
      3'd0: return bridge_mem[off];
      3'd1: return ide_mem[off];
      3'd2: return usb_mem[off];
      default: return power_mem[off];
    endcase
  endfunction

  function logic poke_bridge(logic [7:0] off, logic [7:0] v);
    int ch;
    ch = off[3:1];
    if (off == 8'h04) bridge_mem[off] = (v & 8'h08) | 8'h07;
    else if (off == 8'h06) bridge_mem[off] = bridge_mem[off] & ~(v & 8'hb0);
    else if (off == scs_pkg::CPU_RST_OFF) begin
      bridge_mem[off] = v & 8'hfe;
      return (v & scs_pkg::CPU_RST_BITS) == scs_pkg::CPU_RST_BITS;
    end else if (off == 8'h48 || (off >= 8'h55 && off <= 8'h58) || off == 8'h5b)
      bridge_mem[off] = v;
    else if (off >= scs_pkg::DMA_FIRST_OFF && off <= scs_pkg::DMA_LAST_OFF &&
             off != scs_pkg::DMA_RO_EVEN && off != scs_pkg::DMA_RO_ODD) begin
      if (off[0]) dma_page[ch][11:4] = v;
      else begin
        dma_page[ch][3:0] = v[7:4];
        dma_en[ch] = v[3];
      end
    end else if (off >= scs_pkg::ALIAS_FIRST && off <= scs_pkg::ALIAS_LAST)
      bridge_mem[off - scs_pkg::ALIAS_SHIFT] = v;
    return 1'b0;
  endfunction

  function void poke_ide(logic [7:0] off, logic [7:0] v);
    case (off)
      8'h04: ide_mem[off] = v & 8'h85;
      8'h06: ide_mem[off] = ide_mem[off] & ~(v & 8'hb0);
      8'h09: ide_mem[off] = (v & 8'h05) | 8'h8a;
      8'h10, 8'h18: ide_mem[off] = (v & 8'hf8) | 8'h01;
      8'h14, 8'h1c: ide_mem[off] = (v & 8'hfc) | 8'h01;
      8'h20: ide_mem[off] = (v & 8'hf0) | 8'h01;
      8'h07, 8'h0d, 8'h11, 8'h13, 8'h15, 8'h17, 8'h19, 8'h1b, 8'h1d, 8'h1f, 8'h21, 8'h3c:
        ide_mem[off] = v;
      default: if (off >= 8'h40 && off <= 8'h51) ide_mem[off] = v;
    endcase
  endfunction

  function void poke_usb(logic [7:0] off, logic [7:0] v);
    case (off)
      8'h04: usb_mem[off] = v & 8'h97;
      8'h07: usb_mem[off] = v & 8'h7f;
      8'h20: usb_mem[off] = (v & 8'he0) | 8'h01;
      8'h0d, 8'h21, 8'h3c, 8'h3d, 8'h40, 8'h41, 8'h44, 8'h45, 8'hc0, 8'hc1:
        usb_mem[off] = v;
      default: ;
    endcase
  endfunction

  // note an accepted access and queue its result
  function void note_access(logic op, logic [2:0] fn, logic [7:0] off, logic [7:0] v);
    logic rq;
    rq = 1'b0;
    if (op == scs_pkg::OP_READ) begin
      pending_q.push_back({peek(fn, off), 1'b0});
      return;
    end
    case (fn)
      3'd0: rq = poke_bridge(off, v);
      3'd1: poke_ide(off, v);
      3'd2: poke_usb(off, v);
      3'd3: if (off == 8'h0d || (off >= 8'h40 && off <= 8'h42) ||
                (off >= 8'h44 && off <= 8'h47) || off == 8'h49 ||
                (off >= 8'h50 && off <= 8'h53)) power_mem[off] = v;
      default: ;
    endcase
    pending_q.push_back({8'h00, rq});
  endfunction

  function void report(string what, logic [7:0] got, logic [7:0] want);
    errors++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endfunction

  function void check_result(logic [7:0] rb, logic rq);
    logic [8:0] e;
    if (pending_q.size() == 0) begin
      errors++;
      $display("unexpected result word %h %b", rb, rq);
      return;
    end
    e = pending_q.pop_front();
    if (rb !== e[8:1]) report("read_byte", rb, e[8:1]);
    if (rq !== e[0]) report("cpu_reset_request", {7'd0, rq}, {7'd0, e[0]});
  endfunction
endclass

>>> tb/sv/southbridge_pci_config_space_tb.sv
// top of the config space testbench: drives byte accesses with random
// idling and a long output hold-off, checks every result word
// depends on scs_pkg, scs_if, scs_tb_if.sv and the block under test
`timescale 1ns / 1ps
module southbridge_pci_config_space_tb;
  logic clk;
  logic rst_n;
  scs_in_if  in_word();
  scs_out_if out_word();
  scs_access_board board;
  int in_idle_pct;
  int out_idle_pct;
  int hold_cycles;
  longint cycle_count;

  southbridge_pci_config_space dut (
    .clk(clk), .rst_n(rst_n), .in_word(in_word.sink), .out_word(out_word.source)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // sink side: random stalls plus a counted hold-off
  always @(posedge clk) begin
    if (rst_n && out_word.valid && out_word.ready)
      board.check_result(out_word.read_byte, out_word.cpu_reset_request);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_word.ready <= 1'b0;
    end else
      out_word.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  task automatic send_word(logic op, logic [2:0] fn, logic [7:0] off, logic [7:0] v);
    while ($urandom_range(99) < in_idle_pct) begin
      in_word.valid <= 1'b0;
      @(posedge clk);
    end
    in_word.valid <= 1'b1;
    in_word.opcode <= op;
    in_word.function_number <= fn;
    in_word.offset <= off;
    in_word.write_byte <= v;
    do @(posedge clk); while (!in_word.ready);
    board.note_access(op, fn, off, v);
  endtask

  task automatic send_random();
    logic [7:0] off;
    logic [2:0] fn;
    int pick;
    pick = $urandom_range(99);
    fn = (pick < 90) ? 3'($urandom_range(3)) : 3'($urandom_range(7, 4));
    // mostly hit the interesting low region
    off = ($urandom_range(3) != 0) ? 8'($urandom_range(8'h7f)) : 8'($urandom);
    send_word(1'($urandom_range(1)), fn, off, 8'($urandom));
  endtask

  initial begin
    board = new();
    board.clear_state();
    board.errors = 0;
    in_idle_pct = 0;
    out_idle_pct = 0;
    hold_cycles = 0;
    rst_n = 1'b0;
    in_word.valid = 1'b0;
    in_word.opcode = scs_pkg::OP_READ;
    in_word.function_number = 3'd0;
    in_word.offset = 8'h00;
    in_word.write_byte = 8'h00;
    out_word.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: defaults, cpu reset, dma, alias, clear-on-write, absent function
    send_word(scs_pkg::OP_READ, 3'd0, 8'h00, 8'h00);
    send_word(scs_pkg::OP_WRITE, 3'd0, scs_pkg::CPU_RST_OFF, 8'hff);
    send_word(scs_pkg::OP_READ, 3'd0, scs_pkg::CPU_RST_OFF, 8'h00);
    send_word(scs_pkg::OP_WRITE, 3'd0, scs_pkg::CPU_RST_OFF, 8'h80);
    send_word(scs_pkg::OP_WRITE, 3'd0, 8'h60, 8'hf8);
    send_word(scs_pkg::OP_WRITE, 3'd0, 8'h6f, 8'hff);
    send_word(scs_pkg::OP_WRITE, 3'd0, scs_pkg::DMA_RO_EVEN, 8'hff);
    send_word(scs_pkg::OP_WRITE, 3'd0, scs_pkg::DMA_RO_ODD, 8'hff);
    send_word(scs_pkg::OP_READ, 3'd0, 8'h60, 8'h00);
    send_word(scs_pkg::OP_READ, 3'd0, scs_pkg::DMA_RO_EVEN, 8'h00);
    send_word(scs_pkg::OP_READ, 3'd0, 8'h6f, 8'h00);
    send_word(scs_pkg::OP_WRITE, 3'd0, scs_pkg::ALIAS_LAST, 8'ha5);
    send_word(scs_pkg::OP_READ, 3'd0, 8'h2e, 8'h00);
    send_word(scs_pkg::OP_READ, 3'd0, scs_pkg::ALIAS_FIRST, 8'h00);
    send_word(scs_pkg::OP_WRITE, 3'd1, 8'h06, 8'hff);
    send_word(scs_pkg::OP_READ, 3'd1, 8'h06, 8'h00);
    send_word(scs_pkg::OP_WRITE, 3'd1, 8'h09, 8'h00);
    send_word(scs_pkg::OP_WRITE, 3'd2, 8'hc1, 8'hff);
    send_word(scs_pkg::OP_READ, 3'd2, 8'hc1, 8'h00);
    send_word(scs_pkg::OP_WRITE, 3'd3, 8'h53, 8'h5a);
    send_word(scs_pkg::OP_READ, 3'd3, 8'hff, 8'h00);
    send_word(scs_pkg::OP_WRITE, 3'd7, 8'h04, 8'hff);
    send_word(scs_pkg::OP_READ, 3'd7, 8'hff, 8'h00);
    send_word(scs_pkg::OP_READ, 3'd4, 8'h00, 8'h00);
    // long output hold-off while input keeps offering
    hold_cycles = 60;
    repeat (30) send_random();
    in_idle_pct = 23;
    out_idle_pct = 73;
    repeat (580) send_random();
    in_idle_pct = 73;
    out_idle_pct = 23;
    repeat (580) send_random();
    in_idle_pct = 0;
    out_idle_pct = 0;
    repeat (560) send_random();
    in_word.valid <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.pending_q.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule

>>> southbridge_pci_config_space.f
hdl/scs_pkg.sv
hdl/scs_if.sv
hdl/scs_dma.sv
hdl/southbridge_pci_config_space.sv
hdl/scs_checker.sv
tb/sv/scs_tb_if.sv
tb/sv/southbridge_pci_config_space_tb.sv
